/* rtl/dsfp_pkg.sv */
// Shared types and constants for the dual-sensor frame pairing block.
package dsfp_pkg;

   localparam int TIME_W     = 40;
   localparam int HANDLE_W   = 8;
   localparam int POINTS_W   = 20;
   localparam int COUNT_W    = 2;
   localparam int WINDOW_W   = 20;
   localparam int STALE_W    = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DUAL_INTAKE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAIR_WINDOW  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STALE_WAIT   = 2'd3;

   // Result kinds
   localparam logic [1:0] KIND_A    = 2'd0;
   localparam logic [1:0] KIND_B    = 2'd1;
   localparam logic [1:0] KIND_PAIR = 2'd2;

   typedef struct packed {
      logic                a_valid;
      logic [TIME_W-1:0]   a_time;
      logic [HANDLE_W-1:0] a_handle;
      logic [POINTS_W-1:0] a_points;
      logic                b_valid;
      logic [TIME_W-1:0]   b_time;
      logic [HANDLE_W-1:0] b_handle;
      logic [POINTS_W-1:0] b_points;
   } req_type;

   typedef struct packed {
      logic [1:0]          merge_kind;
      logic [TIME_W-1:0]   merged_time;
      logic [HANDLE_W-1:0] first_handle;
      logic [POINTS_W-1:0] first_points;
      logic [HANDLE_W-1:0] second_handle;
      logic [POINTS_W-1:0] second_points;
   } rsp_type;

   typedef struct packed {
      logic [TIME_W-1:0]   ts;
      logic [HANDLE_W-1:0] hdl;
      logic [POINTS_W-1:0] pts;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH,
      ST_NEWEST,
      ST_LATCH,
      ST_SCAN,
      ST_DECIDE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic capture;
      logic pass;
      logic push;
      logic latch;
      logic scan;
      logic decide;
   } cmd_type;

   typedef struct packed {
      logic single_mode;
      logic pass_ok;
      logic fa_nz;
      logic fb_nz;
      logic scan_last;
      logic emit;
   } sts_type;

endpackage

/* rtl/dual_sensor_frame_pairing.sv */
// Dual-sensor frame pairing: one word per polling round in, at most one merged word out.
// In pass-through mode the result is valid the cycle after acceptance and is held until
// taken. Otherwise a round steps through accept, push, newest-entry read, latch and
// decide, with a scan of every stored B entry in between when both stores hold entries,
// done through the single read port of the B store, and then an output step when a
// result goes out, where it waits in an output register until taken. One round is
// worked on at a time; req_stall is high from the cycle after acceptance until the
// round is finished. Configuration is written through csr_* and is always ready.
module dual_sensor_frame_pairing #(
   parameter int STORE_DEPTH = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  dsfp_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output dsfp_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [dsfp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dsfp_pkg::CSR_DATA_W-1:0] csr_data
);
   import dsfp_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   dsfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   dsfp_datapath #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // A pending result blocks intake
   a_out_blocks_in: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input accepted while a result waits");

   // One result per round
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid)
      else $error("result repeated");

   // Single results carry no second frame
   a_single_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.merge_kind != KIND_PAIR |->
         rsp_data.second_handle == '0 && rsp_data.second_points == '0)
      else $error("single result with second frame");

endmodule

/* rtl/dsfp_ctrl.sv */
// Sequencer for one polling round: intake, newest-entry read, scan, decision, result.
module dsfp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  dsfp_pkg::sts_type sts,
   output dsfp_pkg::cmd_type cmd
);
   import dsfp_pkg::*;

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (sts.single_mode) begin
                  if (sts.pass_ok) begin
                     cmd.pass = 1'b1;
                     state_in = ST_OUT;
                  end
               end else begin
                  state_in = ST_PUSH;
               end
            end
         end
         ST_PUSH: begin
            cmd.push = 1'b1;
            state_in = ST_NEWEST;
         end
         ST_NEWEST: begin
            state_in = ST_LATCH;
         end
         ST_LATCH: begin
            cmd.latch = 1'b1;
            cmd.scan  = 1'b1;
            state_in  = (sts.fa_nz && sts.fb_nz) ? ST_SCAN : ST_DECIDE;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = sts.emit ? ST_OUT : ST_IDLE;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/dsfp_datapath.sv */
// Frame stores, configuration registers, nearest-time scan and result register.
module dsfp_datapath #(
   parameter int STORE_DEPTH = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   input  dsfp_pkg::cmd_type                  cmd,
   output dsfp_pkg::sts_type                  sts,
   input  dsfp_pkg::req_type                  req_data,
   output dsfp_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   input  logic [dsfp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dsfp_pkg::CSR_DATA_W-1:0]    csr_data
);
   import dsfp_pkg::*;

   localparam int IW = $clog2(STORE_DEPTH);
   localparam int FW = $clog2(STORE_DEPTH + 1);
   localparam int SW = IW + 2;
   localparam logic [SW-1:0] DEPTH_S = SW'(STORE_DEPTH);
   localparam logic [FW-1:0] DEPTH_F = FW'(STORE_DEPTH);

   // Fold a sum below twice the depth back into the ring
   function automatic logic [IW-1:0] wrap(input logic [SW-1:0] s);
      logic [SW-1:0] r;
      r = (s >= DEPTH_S) ? (s - DEPTH_S) : s;
      return r[IW-1:0];
   endfunction

   // Configuration
   logic [COUNT_W-1:0]  sensor_count_ff;
   logic                dual_intake_ff;
   logic [WINDOW_W-1:0] pair_window_ff;
   logic [STALE_W-1:0]  stale_wait_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_count_ff <= COUNT_W'(2);
         dual_intake_ff  <= 1'b1;
         pair_window_ff  <= WINDOW_W'(50000);
         stale_wait_ff   <= STALE_W'(150000);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SENSOR_COUNT: sensor_count_ff <= csr_data[COUNT_W-1:0];
            CSR_DUAL_INTAKE:  dual_intake_ff  <= csr_data[0];
            CSR_PAIR_WINDOW:  pair_window_ff  <= csr_data[WINDOW_W-1:0];
            CSR_STALE_WAIT:   stale_wait_ff   <= csr_data[STALE_W-1:0];
            default: ;
         endcase
      end
   end

   // Captured round
   req_type req_ff;
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
   end

   // Ring pointers and last arrival times
   logic [IW-1:0]     head_a_ff, head_a_in, head_b_ff, head_b_in;
   logic [FW-1:0]     fill_a_ff, fill_a_in, fill_b_ff, fill_b_in;
   logic [TIME_W-1:0] last_a_ff, last_a_in, last_b_ff, last_b_in;

   logic push_a, push_b, full_a, full_b;
   logic [IW-1:0] wa_a, wa_b, ra_a, ra_b, scan_addr;

   assign push_a = cmd.push && req_ff.a_valid;
   assign push_b = cmd.push && req_ff.b_valid && dual_intake_ff;
   assign full_a = (fill_a_ff == DEPTH_F);
   assign full_b = (fill_b_ff == DEPTH_F);
   assign wa_a   = full_a ? head_a_ff : wrap(SW'(head_a_ff) + SW'(fill_a_ff));
   assign wa_b   = full_b ? head_b_ff : wrap(SW'(head_b_ff) + SW'(fill_b_ff));

   // Memories
   entry_type mem_a [STORE_DEPTH];
   entry_type mem_b [STORE_DEPTH];
   entry_type rd_a_ff, rd_b_ff;

   always_ff @(posedge clock) begin
      if (push_a) begin
         mem_a[wa_a] <= '{ts: req_ff.a_time, hdl: req_ff.a_handle, pts: req_ff.a_points};
      end
      rd_a_ff <= mem_a[ra_a];
   end

   always_ff @(posedge clock) begin
      if (push_b) begin
         mem_b[wa_b] <= '{ts: req_ff.b_time, hdl: req_ff.b_handle, pts: req_ff.b_points};
      end
      rd_b_ff <= mem_b[ra_b];
   end

   // Scan bookkeeping
   logic [FW-1:0]       scan_cnt_ff, didx_ff, best_idx_ff;
   logic                dv_ff, matched_ff;
   logic [TIME_W-1:0]   best_dt_ff;
   entry_type           best_ff;
   entry_type           newest_a_ff;
   entry_type           newest_b_ff;

   assign ra_a      = wrap(SW'(head_a_ff) + SW'(fill_a_ff) - SW'(1));
   assign scan_addr = wrap(SW'(head_b_ff) + SW'(scan_cnt_ff));
   assign ra_b      = cmd.scan ? scan_addr : wrap(SW'(head_b_ff) + SW'(fill_b_ff) - SW'(1));

   logic [TIME_W-1:0] dt;
   logic              hit, issue;
   assign dt    = (newest_a_ff.ts > rd_b_ff.ts) ? (newest_a_ff.ts - rd_b_ff.ts)
                                                : (rd_b_ff.ts - newest_a_ff.ts);
   assign hit   = cmd.scan && dv_ff && (dt < TIME_W'(pair_window_ff))
                  && (!matched_ff || dt < best_dt_ff);
   assign issue = cmd.scan && (scan_cnt_ff < fill_b_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff       <= 1'b0;
         matched_ff  <= 1'b0;
         scan_cnt_ff <= '0;
      end else if (cmd.capture) begin
         dv_ff       <= 1'b0;
         matched_ff  <= 1'b0;
         scan_cnt_ff <= '0;
      end else begin
         // issue the next entry and compare the one read last cycle
         if (cmd.scan) begin
            dv_ff <= issue;
         end
         if (issue) begin
            scan_cnt_ff <= scan_cnt_ff + FW'(1);
         end
         if (hit) begin
            matched_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         didx_ff <= scan_cnt_ff;
      end
      if (hit) begin
         best_dt_ff  <= dt;
         best_idx_ff <= didx_ff;
         best_ff     <= rd_b_ff;
      end
      if (cmd.latch) begin
         newest_a_ff <= rd_a_ff;
         newest_b_ff <= rd_b_ff;
      end
   end

   // Decision
   logic                fa_nz, fb_nz, go, use_b, emit;
   logic [TIME_W-1:0]   st_n, st_r;
   logic [POINTS_W:0]   psum;
   logic [POINTS_W-1:0] single_pts;
   rsp_type             dec_rsp;

   assign fa_nz = (fill_a_ff != '0);
   assign fb_nz = (fill_b_ff != '0);
   assign psum  = {1'b0, newest_a_ff.pts} + {1'b0, best_ff.pts};

   always_comb begin
      if (fa_nz && !fb_nz) begin
         st_n = newest_a_ff.ts;
         st_r = last_b_ff;
      end else if (!fa_nz && fb_nz) begin
         st_n = newest_b_ff.ts;
         st_r = last_a_ff;
      end else if (newest_a_ff.ts > newest_b_ff.ts) begin
         st_n = newest_a_ff.ts;
         st_r = newest_b_ff.ts;
      end else begin
         st_n = newest_b_ff.ts;
         st_r = newest_a_ff.ts;
      end
   end

   assign go         = (fa_nz || fb_nz) && (st_n > st_r)
                       && ((st_n - st_r) > TIME_W'(stale_wait_ff));
   assign use_b      = !fa_nz;
   assign single_pts = use_b ? newest_b_ff.pts : newest_a_ff.pts;

   always_comb begin
      dec_rsp = '0;
      if (matched_ff) begin
         dec_rsp.merge_kind    = KIND_PAIR;
         dec_rsp.merged_time   = (newest_a_ff.ts < best_ff.ts) ? newest_a_ff.ts : best_ff.ts;
         dec_rsp.first_handle  = newest_a_ff.hdl;
         dec_rsp.first_points  = newest_a_ff.pts;
         dec_rsp.second_handle = best_ff.hdl;
         dec_rsp.second_points = best_ff.pts;
         emit                  = (psum != '0);
      end else begin
         dec_rsp.merge_kind   = use_b ? KIND_B : KIND_A;
         dec_rsp.merged_time  = use_b ? newest_b_ff.ts : newest_a_ff.ts;
         dec_rsp.first_handle = use_b ? newest_b_ff.hdl : newest_a_ff.hdl;
         dec_rsp.first_points = single_pts;
         emit                 = go && (single_pts != '0);
      end
   end

   // Pointer updates from push and decide
   always_comb begin
      head_a_in = head_a_ff;
      head_b_in = head_b_ff;
      fill_a_in = fill_a_ff;
      fill_b_in = fill_b_ff;
      last_a_in = last_a_ff;
      last_b_in = last_b_ff;
      if (push_a) begin
         last_a_in = req_ff.a_time;
         if (full_a) head_a_in = wrap(SW'(head_a_ff) + SW'(1));
         else        fill_a_in = fill_a_ff + FW'(1);
      end
      if (push_b) begin
         last_b_in = req_ff.b_time;
         if (full_b) head_b_in = wrap(SW'(head_b_ff) + SW'(1));
         else        fill_b_in = fill_b_ff + FW'(1);
      end
      if (cmd.decide) begin
         if (matched_ff) begin
            fill_a_in = '0;
            head_b_in = wrap(SW'(head_b_ff) + SW'(best_idx_ff) + SW'(1));
            fill_b_in = fill_b_ff - best_idx_ff - FW'(1);
         end else if (go) begin
            if (use_b) fill_b_in = fill_b_ff - FW'(1);
            else       fill_a_in = fill_a_ff - FW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_a_ff <= '0;
         head_b_ff <= '0;
         fill_a_ff <= '0;
         fill_b_ff <= '0;
         last_a_ff <= '0;
         last_b_ff <= '0;
      end else begin
         head_a_ff <= head_a_in;
         head_b_ff <= head_b_in;
         fill_a_ff <= fill_a_in;
         fill_b_ff <= fill_b_in;
         last_a_ff <= last_a_in;
         last_b_ff <= last_b_in;
      end
   end

   // Result register
   rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      if (cmd.pass) begin
         rsp_ff <= '{merge_kind: KIND_A, merged_time: req_data.a_time,
                     first_handle: req_data.a_handle, first_points: req_data.a_points,
                     second_handle: '0, second_points: '0};
      end else if (cmd.decide && emit) begin
         rsp_ff <= dec_rsp;
      end
   end
   assign rsp_data = rsp_ff;

   // Status
   assign sts.single_mode = (sensor_count_ff == COUNT_W'(1));
   assign sts.pass_ok     = req_data.a_valid;
   assign sts.fa_nz       = fa_nz;
   assign sts.fb_nz       = fb_nz;
   assign sts.scan_last   = dv_ff && (didx_ff == fill_b_ff - FW'(1));
   assign sts.emit        = emit;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the dual-sensor frame pairing block.
`timescale 1ns / 100ps

module tb_top;
   import dsfp_pkg::*;

   localparam int DEPTH       = 10;
   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE      = 40;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   dual_sensor_frame_pairing #(.STORE_DEPTH(DEPTH)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow configuration and frame stores of the pairing predictor
   logic [COUNT_W-1:0]  sensors_cfg  = 2'd2;
   logic                dual_cfg     = 1'b1;
   logic [WINDOW_W-1:0] window_cfg   = 20'd50000;
   logic [STALE_W-1:0]  stale_cfg    = 24'd150000;
   entry_type           a_frames[$];
   entry_type           b_frames[$];
   logic [TIME_W-1:0]   a_last = '0;
   logic [TIME_W-1:0]   b_last = '0;

   req_type pending_rounds[$];
   rsp_type merged_expected[$];
   int      mismatches = 0;
   int      merged_seen = 0;
   int      cycles = 0;

   function automatic logic [TIME_W-1:0] abs_diff(logic [TIME_W-1:0] x, logic [TIME_W-1:0] y);
      return (x > y) ? x - y : y - x;
   endfunction

   function automatic bit aged_out(logic [TIME_W-1:0] newest, logic [TIME_W-1:0] ref_t);
      return (newest > ref_t) && ((newest - ref_t) > stale_cfg);
   endfunction

   function automatic entry_type mk_entry(logic [TIME_W-1:0] t, logic [HANDLE_W-1:0] h,
                                          logic [POINTS_W-1:0] p);
      entry_type e;
      e.ts = t; e.hdl = h; e.pts = p;
      return e;
   endfunction

   // Work out the merged word (if any) caused by one polling round
   function automatic void pair_round(req_type r);
      rsp_type           m;
      bit                found;
      int                best;
      logic [TIME_W-1:0] best_dt, dt, ta, tb;
      entry_type         ea, eb;
      int                src;
      m = '0; found = 0; best = 0; best_dt = '0; src = -1;
      if (sensors_cfg == 2'd1) begin
         if (r.a_valid) begin
            m.merge_kind = KIND_A; m.merged_time = r.a_time;
            m.first_handle = r.a_handle; m.first_points = r.a_points;
            merged_expected.insert(merged_expected.size(), m);
         end
         return;
      end
      if (r.a_valid) begin
         if (a_frames.size() >= DEPTH) void'(a_frames.pop_front());
         a_frames.insert(a_frames.size(), mk_entry(r.a_time, r.a_handle, r.a_points));
         a_last = r.a_time;
      end
      if (dual_cfg && r.b_valid) begin
         if (b_frames.size() >= DEPTH) void'(b_frames.pop_front());
         b_frames.insert(b_frames.size(), mk_entry(r.b_time, r.b_handle, r.b_points));
         b_last = r.b_time;
      end
      if (a_frames.size() > 0 && b_frames.size() > 0) begin
         ta = a_frames[$].ts;
         foreach (b_frames[j]) begin
            dt = abs_diff(ta, b_frames[j].ts);
            if (dt < window_cfg && (!found || dt < best_dt)) begin
               found = 1; best_dt = dt; best = j;
            end
         end
         if (found) begin
            ea = a_frames[$];
            eb = b_frames[best];
            a_frames.delete();
            for (int k = 0; k <= best; k++) void'(b_frames.pop_front());
            if ({1'b0, ea.pts} + {1'b0, eb.pts} == 0) return;
            m.merge_kind = KIND_PAIR;
            m.merged_time = (ea.ts < eb.ts) ? ea.ts : eb.ts;
            m.first_handle = ea.hdl; m.first_points = ea.pts;
            m.second_handle = eb.hdl; m.second_points = eb.pts;
            merged_expected.insert(merged_expected.size(), m);
            return;
         end
      end
      if (a_frames.size() > 0 && b_frames.size() == 0) begin
         if (aged_out(a_frames[$].ts, b_last)) src = 0;
      end else if (a_frames.size() == 0 && b_frames.size() > 0) begin
         if (aged_out(b_frames[$].ts, a_last)) src = 1;
      end else if (a_frames.size() > 0 && b_frames.size() > 0) begin
         if (abs_diff(a_frames[$].ts, b_frames[$].ts) > stale_cfg) src = 0;
      end
      if (src < 0) return;
      if (src == 0) begin
         ea = a_frames[$];
         a_frames.delete(a_frames.size() - 1);
         m.merge_kind = KIND_A;
      end else begin
         ea = b_frames[$];
         b_frames.delete(b_frames.size() - 1);
         m.merge_kind = KIND_B;
      end
      if (ea.pts == 0) return;
      m.merged_time = ea.ts; m.first_handle = ea.hdl; m.first_points = ea.pts;
      merged_expected.insert(merged_expected.size(), m);
   endfunction

   // Driver: offer rounds in bursts, hold each word until taken
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (req_valid && !req_stall) pair_round(req_data);
      if (!req_valid || !req_stall) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_rounds.size() > 0) begin
            req_data <= pending_rounds.pop_front();
            req_valid <= 1'b1;
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 20);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: check each merged word, stall on its own pattern
   int stall_mode = 0;
   int mode_left = 0;
   int hold_left = 0;
   bit held_once = 0;
   always @(posedge clock) begin
      rsp_type want;
      cycles <= cycles + 1;
      if (rsp_valid && !rsp_stall) begin
         merged_seen <= merged_seen + 1;
         if (merged_expected.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("unexpected word: %p", rsp_data);
         end else begin
            want = merged_expected.pop_front();
            if (want.merge_kind != rsp_data.merge_kind ||
                want.merged_time != rsp_data.merged_time ||
                want.first_handle != rsp_data.first_handle ||
                want.first_points != rsp_data.first_points ||
                want.second_handle != rsp_data.second_handle ||
                want.second_points != rsp_data.second_points) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("mismatch: expected %p actual %p", want, rsp_data);
            end
         end
      end
      // long hold-off once, so the block backs up into its input
      if (!held_once && merged_seen == 40) begin
         held_once <= 1;
         hold_left <= 400;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= (hold_left > 1);
      end else begin
         if (mode_left == 0) begin
            mode_left <= $urandom_range(50, 300);
            stall_mode <= $urandom_range(0, 3);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 1) == 0);
            default: rsp_stall <= ($urandom_range(0, 9) != 0);
         endcase
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Caller stands at a rising edge; the write lands at the edge with ready
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_SENSOR_COUNT: sensors_cfg = val[COUNT_W-1:0];
         CSR_DUAL_INTAKE:  dual_cfg = val[0];
         CSR_PAIR_WINDOW:  window_cfg = val[WINDOW_W-1:0];
         default:          stale_cfg = val[STALE_W-1:0];
      endcase
   endtask

   task automatic set_mode(int sc, int di, int win, int stl);
      write_reg(CSR_SENSOR_COUNT, CSR_DATA_W'(sc));
      write_reg(CSR_DUAL_INTAKE, CSR_DATA_W'(di));
      write_reg(CSR_PAIR_WINDOW, CSR_DATA_W'(win));
      write_reg(CSR_STALE_WAIT, CSR_DATA_W'(stl));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (pending_rounds.size() > 0 || req_valid || merged_expected.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic req_type mk_round(bit av, logic [TIME_W-1:0] at, logic [HANDLE_W-1:0] ah,
                                        logic [POINTS_W-1:0] ap, bit bv,
                                        logic [TIME_W-1:0] bt, logic [HANDLE_W-1:0] bh,
                                        logic [POINTS_W-1:0] bp);
      req_type r;
      r.a_valid = av; r.a_time = at; r.a_handle = ah; r.a_points = ap;
      r.b_valid = bv; r.b_time = bt; r.b_handle = bh; r.b_points = bp;
      return r;
   endfunction

   // Append one round to the pending queue
   function automatic void add_round(req_type r);
      pending_rounds.insert(pending_rounds.size(), r);
   endfunction

   function automatic logic [POINTS_W-1:0] rand_points();
      return ($urandom_range(0, 9) == 0) ? '0 : POINTS_W'($urandom);
   endfunction

   // Mostly a plausible timeline with jitter; some noise words and jumps
   task automatic queue_random(int n);
      logic [TIME_W-1:0] base;
      req_type           r;
      base = TIME_W'({$urandom, $urandom});
      repeat (n) begin
         if ($urandom_range(0, 99) < 8) begin
            r = $bits(req_type)'({$urandom, $urandom, $urandom, $urandom, $urandom});
         end else begin
            if ($urandom_range(0, 49) == 0) base = TIME_W'({$urandom, $urandom});
            base = base + $urandom_range(1000, 70000);
            r = mk_round($urandom_range(0, 3) != 0, base + $urandom_range(0, 5000),
                         HANDLE_W'($urandom), rand_points(),
                         $urandom_range(0, 3) != 0,
                         base + $urandom_range(0, 80000) - 40000,
                         HANDLE_W'($urandom), rand_points());
         end
         add_round(r);
      end
   endtask

   initial begin
      logic [TIME_W-1:0] tmax;
      tmax = '1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_mode(2, 1, 50000, 150000);

      // directed rounds: pairs, window edge, ties, stale singles, zero points, extremes
      add_round(mk_round(1'b1, 40'd1000, 8'h00, 20'd5, 1'b0, '0, '0, '0));
      add_round(mk_round(1'b0, '0, '0, '0, 1'b1, 40'd20000, 8'hff, 20'hfffff));
      add_round(mk_round(1'b1, 40'd100000, 8'h11, 20'd1, 1'b1, 40'd149999, 8'h22, 20'd2));
      add_round(mk_round(1'b1, 40'd300000, 8'h33, 20'd3, 1'b1, 40'd350000, 8'h44, 20'd4));
      add_round(mk_round(1'b0, '0, '0, '0, 1'b1, 40'd250000, 8'h55, 20'd5));
      add_round(mk_round(1'b1, 40'd260000, 8'h66, 20'd0, 1'b0, '0, '0, '0));
      add_round(mk_round(1'b1, 40'd500000, 8'h77, 20'd0, 1'b1, 40'd500000, 8'h88, 20'd0));
      add_round(mk_round(1'b1, 40'd900000, 8'h99, 20'd7, 1'b0, '0, '0, '0));
      add_round(mk_round(1'b0, '0, '0, '0, 1'b1, 40'd2000000, 8'haa, 20'd0));
      add_round(mk_round(1'b0, '0, '0, '0, 1'b1, 40'd2100000, 8'hbb, 20'd9));
      add_round(mk_round(1'b1, 40'd1000, 8'hcc, 20'd9, 1'b0, '0, '0, '0));
      for (int i = 0; i < 11; i++)
         add_round(mk_round(1'b1, 40'd5000000 + TIME_W'(i), HANDLE_W'(i), POINTS_W'(i + 1),
                            1'b0, '0, '0, '0));
      add_round(mk_round(1'b1, tmax, 8'hff, 20'hfffff, 1'b1, tmax - 1, 8'h01, 20'hfffff));
      add_round(mk_round(1'b0, tmax, '1, '1, 1'b1, '0, '0, '1));
      add_round(mk_round(1'b0, '0, '0, '0, 1'b0, '0, '0, '0));
      drain();

      queue_random(150);
      drain();
      set_mode(1, 1, 50000, 150000);
      queue_random(80);
      drain();
      set_mode(2, 0, 50000, 150000);
      queue_random(80);
      drain();
      set_mode(3, 1, 0, 0);
      queue_random(70);
      drain();
      set_mode(0, 1, 1000000, 10000000);
      queue_random(80);
      drain();
      set_mode(2, 1, 1, 1);
      queue_random(60);
      drain();
      repeat (2) begin
         set_mode($urandom_range(0, 3), $urandom_range(0, 1),
                  $urandom_range(0, 1000000), $urandom_range(0, 300000));
         queue_random(70);
         drain();
      end

      if (mismatches == 0 && merged_expected.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/dsfp_pkg.sv
rtl/dsfp_ctrl.sv
rtl/dsfp_datapath.sv
rtl/dual_sensor_frame_pairing.sv
tb/tb_top.sv
